// ===== design/stmax_pkg.sv =====
// shared types, constants and the signed max helper for the range max tree
package stmax_pkg;

	localparam int DATA_W         = 32;
	localparam int DEF_LEAF_COUNT = 1024;
	localparam int FIRST_W        = 10;
	localparam int END_W          = 11;

	typedef logic signed [DATA_W-1:0] data_t;

	localparam data_t MIN_VAL = {1'b1, {(DATA_W-1){1'b0}}};

	localparam logic OP_SET   = 1'b0;
	localparam logic OP_QUERY = 1'b1;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_U_LEAF,
		ST_U_READ,
		ST_U_WRITE,
		ST_Q_TEST,
		ST_Q_ACC_B,
		ST_Q_ACC_E,
		ST_Q_FINISH
	} state_t;

	typedef enum logic [1:0] {
		RD_B,
		RD_E,
		RD_SIB
	} rd_sel_t;

	typedef struct packed {
		logic    clr_step;
		logic    load;
		logic    leaf_wr;
		logic    up_wr;
		logic    mem_re;
		rd_sel_t rd_sel;
		logic    acc_b;
		logic    acc_e;
		logic    shift;
		logic    post;
	} ctrl_cmd_t;

	typedef struct packed {
		logic clr_last;
		logic is_query;
		logic upd_skip;
		logic u_root;
		logic parent_root;
		logic q_more;
		logic b_odd;
		logic e_odd;
		logic out_room;
	} ctrl_sts_t;

	function automatic data_t smax(input data_t a, input data_t b);
		smax = (a >= b) ? a : b;
	endfunction

endpackage

// ===== design/stmax_ctrl.sv =====
// sequencer for clear pass, leaf update walk and range query walk
module stmax_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  req_valid,
	output logic                  req_stall,
	input  stmax_pkg::ctrl_sts_t  sts,
	output stmax_pkg::ctrl_cmd_t  cmd
);
	import stmax_pkg::*;

	state_t state_q;
	state_t state_nxt;
	logic   take;

	assign take = req_valid && (state_q == ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ST_CLEAR: begin
				if (sts.clr_last) state_nxt = ST_IDLE;
			end
			ST_IDLE: begin
				if (take) begin
					if (sts.is_query) state_nxt = ST_Q_TEST;
					else if (!sts.upd_skip) state_nxt = ST_U_LEAF;
				end
			end
			ST_U_LEAF: begin
				state_nxt = sts.u_root ? ST_IDLE : ST_U_READ;
			end
			ST_U_READ: begin
				state_nxt = ST_U_WRITE;
			end
			ST_U_WRITE: begin
				state_nxt = sts.parent_root ? ST_IDLE : ST_U_READ;
			end
			ST_Q_TEST: begin
				priority if (!sts.q_more) state_nxt = ST_Q_FINISH;
				else if (sts.b_odd) state_nxt = ST_Q_ACC_B;
				else if (sts.e_odd) state_nxt = ST_Q_ACC_E;
				else state_nxt = ST_Q_TEST;
			end
			ST_Q_ACC_B: begin
				state_nxt = sts.e_odd ? ST_Q_ACC_E : ST_Q_TEST;
			end
			ST_Q_ACC_E: begin
				state_nxt = ST_Q_TEST;
			end
			ST_Q_FINISH: begin
				if (sts.out_room) state_nxt = ST_IDLE;
			end
			default: state_nxt = ST_CLEAR;
		endcase
	end

	always_comb begin
		cmd        = '0;
		cmd.rd_sel = RD_B;
		req_stall  = (state_q != ST_IDLE);
		unique case (state_q)
			ST_CLEAR: cmd.clr_step = 1'b1;
			ST_IDLE:  cmd.load = take;
			ST_U_LEAF: cmd.leaf_wr = 1'b1;
			ST_U_READ: begin
				cmd.mem_re = 1'b1;
				cmd.rd_sel = RD_SIB;
			end
			ST_U_WRITE: cmd.up_wr = 1'b1;
			ST_Q_TEST: begin
				priority if (!sts.q_more) begin
					cmd.mem_re = 1'b0;
				end else if (sts.b_odd) begin
					cmd.mem_re = 1'b1;
					cmd.rd_sel = RD_B;
				end else if (sts.e_odd) begin
					cmd.mem_re = 1'b1;
					cmd.rd_sel = RD_E;
				end else begin
					cmd.shift = 1'b1;
				end
			end
			ST_Q_ACC_B: begin
				cmd.acc_b = 1'b1;
				if (sts.e_odd) begin
					cmd.mem_re = 1'b1;
					cmd.rd_sel = RD_E;
				end else begin
					cmd.shift = 1'b1;
				end
			end
			ST_Q_ACC_E: begin
				cmd.acc_e = 1'b1;
				cmd.shift = 1'b1;
			end
			ST_Q_FINISH: cmd.post = sts.out_room;
			default: cmd = '0;
		endcase
	end

endmodule

// ===== design/stmax_dp.sv =====
// node memory, boundary pointers, accumulators and result register
module stmax_dp #(
	parameter int LEAF_COUNT = stmax_pkg::DEF_LEAF_COUNT
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          op,
	input  logic [stmax_pkg::FIRST_W-1:0] first_index,
	input  logic [stmax_pkg::END_W-1:0]   end_index,
	input  stmax_pkg::data_t              value,
	output logic                          rsp_valid,
	input  logic                          rsp_stall,
	output stmax_pkg::data_t              range_max,
	input  stmax_pkg::ctrl_cmd_t          cmd,
	output stmax_pkg::ctrl_sts_t          sts
);
	import stmax_pkg::*;

	localparam int DEPTH = 2 * LEAF_COUNT;
	localparam int AW    = $clog2(DEPTH);
	localparam int CL    = $clog2(LEAF_COUNT);
	localparam int PW    = ((CL > FIRST_W) ? CL : FIRST_W) + 2;

	localparam logic [PW-1:0] LC_P    = PW'(LEAF_COUNT);
	localparam logic [PW-1:0] ONE_P   = PW'(1);
	localparam logic [AW-1:0] LAST_A  = AW'(DEPTH - 1);

	data_t mem [DEPTH];

	logic [PW-1:0] ptr_b_q;
	logic [PW-1:0] ptr_e_q;
	data_t         acc_l_q;
	data_t         acc_r_q;
	data_t         upd_acc_q;
	data_t         rd_q;
	data_t         result_q;
	logic          out_valid_q;
	logic [AW-1:0] clr_q;

	logic [PW-1:0] first_ext;
	logic [PW-1:0] end_ext;
	logic [PW-1:0] end_sat;
	logic [PW-1:0] e_dec;
	logic [PW-1:0] parent;
	logic [PW-1:0] rd_ptr;
	logic [AW-1:0] rd_addr;
	logic [AW-1:0] wr_addr;
	logic          mem_we;
	data_t         wr_data;
	data_t         up_max;

	assign first_ext = PW'(first_index);
	assign end_ext   = PW'(end_index);
	assign end_sat   = (end_ext > LC_P) ? LC_P : end_ext;
	assign e_dec     = ptr_e_q - ONE_P;
	assign parent    = ptr_b_q >> 1;
	assign up_max    = smax(upd_acc_q, rd_q);

	always_comb begin
		unique case (cmd.rd_sel)
			RD_E:    rd_ptr = e_dec;
			RD_SIB:  rd_ptr = {ptr_b_q[PW-1:1], ~ptr_b_q[0]};
			default: rd_ptr = ptr_b_q;
		endcase
	end
	assign rd_addr = rd_ptr[AW-1:0];

	assign mem_we = cmd.clr_step | cmd.leaf_wr | cmd.up_wr;

	always_comb begin
		priority if (cmd.clr_step) begin
			wr_addr = clr_q;
			wr_data = MIN_VAL;
		end else if (cmd.leaf_wr) begin
			wr_addr = ptr_b_q[AW-1:0];
			wr_data = upd_acc_q;
		end else begin
			wr_addr = parent[AW-1:0];
			wr_data = up_max;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[wr_addr] <= wr_data;
		end
		if (cmd.mem_re) begin
			rd_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
		end else if (cmd.clr_step) begin
			clr_q <= clr_q + AW'(1);
		end
	end

	// boundary walk: left moves past an odd node, right drops below one
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			ptr_b_q   <= first_ext + LC_P;
			ptr_e_q   <= end_sat + LC_P;
			acc_l_q   <= MIN_VAL;
			acc_r_q   <= MIN_VAL;
			upd_acc_q <= value;
		end else begin
			if (cmd.up_wr) begin
				ptr_b_q   <= parent;
				upd_acc_q <= up_max;
			end
			if (cmd.shift) begin
				ptr_b_q <= (ptr_b_q + PW'(ptr_b_q[0])) >> 1;
				ptr_e_q <= ptr_e_q >> 1;
			end
			if (cmd.acc_b) begin
				acc_l_q <= smax(acc_l_q, rd_q);
			end
			if (cmd.acc_e) begin
				acc_r_q <= smax(rd_q, acc_r_q);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.post) begin
			result_q <= smax(acc_l_q, acc_r_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.post) begin
			out_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	assign rsp_valid = out_valid_q;
	assign range_max = result_q;

	assign sts.clr_last    = (clr_q == LAST_A);
	assign sts.is_query    = (op == OP_QUERY);
	assign sts.upd_skip    = (first_ext >= LC_P);
	assign sts.u_root      = (ptr_b_q == ONE_P);
	assign sts.parent_root = (parent == ONE_P);
	assign sts.q_more      = (ptr_b_q < ptr_e_q);
	assign sts.b_odd       = ptr_b_q[0];
	assign sts.e_odd       = ptr_e_q[0];
	assign sts.out_room    = !out_valid_q || !rsp_stall;

	a_one_access: assert property (@(posedge clk) disable iff (!arst_n)
		!(mem_we && cmd.mem_re))
		else $error("node memory read and written in one cycle");

	a_read_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.mem_re |-> (rd_ptr < PW'(DEPTH)))
		else $error("node read beyond the tree");

	a_post_room: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.post |-> sts.out_room)
		else $error("result posted over an untaken word");

	a_valid_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(cmd.post))
		else $error("result word appeared without a finished query");

endmodule

// ===== design/segment_tree_range_max_top.sv =====
// Range max segment tree over LEAF_COUNT signed 32-bit leaves, one node
// memory of 2*LEAF_COUNT words. After reset the block clears every node to
// the most negative integer, one node a cycle, and stalls requests until
// the clear pass is done. An update (op 0) writes its leaf, then reads each
// sibling and writes each parent up to the root, keeping the block busy so
// no new request is taken meanwhile; it gives no word. An update to a leaf
// past the tree is dropped. A query (op 1) climbs the two boundaries level
// by level until they meet, reading and combining each odd boundary node,
// and waits to post while an earlier word is still stalled. The single
// node memory port with its registered read data sets the pace, since each
// boundary node taken in needs a read then a combine. A query result sits
// in an output register, so the next request is taken while it waits; an
// empty range returns the most negative integer.
module segment_tree_range_max_top #(
	parameter int LEAF_COUNT = stmax_pkg::DEF_LEAF_COUNT
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          req_valid,
	output logic                          req_stall,
	input  logic                          op,
	input  logic [stmax_pkg::FIRST_W-1:0] first_index,
	input  logic [stmax_pkg::END_W-1:0]   end_index,
	input  stmax_pkg::data_t              value,
	output logic                          rsp_valid,
	input  logic                          rsp_stall,
	output stmax_pkg::data_t              range_max
);
	import stmax_pkg::*;

	ctrl_cmd_t cmd;
	ctrl_sts_t sts;

	stmax_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	stmax_dp #(
		.LEAF_COUNT (LEAF_COUNT)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.op          (op),
		.first_index (first_index),
		.end_index   (end_index),
		.value       (value),
		.rsp_valid   (rsp_valid),
		.rsp_stall   (rsp_stall),
		.range_max   (range_max),
		.cmd         (cmd),
		.sts         (sts)
	);

endmodule
